[sv/mcs_pkg.sv]
package mcs_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned DurW      = 18;
  localparam int unsigned UnitsW    = 3;
  localparam int unsigned SymW      = 4;
  localparam int unsigned CntW      = 3;
  localparam int unsigned IdxW      = 2;
  localparam int unsigned LetterW   = 5;
  localparam int unsigned PatW      = 7;
  localparam int unsigned OutDataW  = 24;

  localparam logic [CntW-1:0]   MaxSymbols   = 3'd4;
  localparam logic [UnitW-1:0]  UnitReset    = 16'd100;

  localparam logic [CharW-1:0]  ChrUpperA    = 8'h41;
  localparam logic [CharW-1:0]  ChrUpperZ    = 8'h5A;
  localparam logic [CharW-1:0]  ChrLowerA    = 8'h61;
  localparam logic [CharW-1:0]  ChrLowerZ    = 8'h7A;
  localparam logic [CharW-1:0]  CaseFold     = 8'h20;
  localparam logic [CharW-1:0]  ChrSpace     = 8'h20;
  localparam logic [CharW-1:0]  ChrTab       = 8'h09;
  localparam logic [CharW-1:0]  ChrCr        = 8'h0D;

  localparam logic [UnitsW-1:0] UnitsDot     = 3'd1;
  localparam logic [UnitsW-1:0] UnitsDash    = 3'd3;
  localparam logic [UnitsW-1:0] UnitsSymGap  = 3'd1;
  localparam logic [UnitsW-1:0] UnitsLetEnd  = 3'd2;
  localparam logic [UnitsW-1:0] UnitsWordGap = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYM_ON,
    ST_SYM_OFF,
    ST_LETTER_END,
    ST_WORD_GAP
  } mcs_state_e;

  typedef enum logic [1:0] {
    SEG_ON,
    SEG_GAP,
    SEG_END,
    SEG_WORD
  } mcs_seg_e;

  typedef struct packed {
    logic     load;
    logic     emit;
    logic     advance;
    mcs_seg_e seg;
  } mcs_cmd_t;

  typedef struct packed {
    logic in_letter;
    logic in_space;
    logic in_has_syms;
    logic sym_last;
    logic out_free;
  } mcs_status_t;

  function automatic logic [PatW-1:0] letter_pattern(input logic [LetterW-1:0] idx);
    logic [PatW-1:0] p;
    case (idx)
      5'd0:    p = 7'h22;
      5'd1:    p = 7'h41;
      5'd2:    p = 7'h45;
      5'd3:    p = 7'h31;
      5'd4:    p = 7'h10;
      5'd5:    p = 7'h44;
      5'd6:    p = 7'h33;
      5'd7:    p = 7'h40;
      5'd8:    p = 7'h20;
      5'd9:    p = 7'h4E;
      5'd10:   p = 7'h35;
      5'd11:   p = 7'h42;
      5'd12:   p = 7'h23;
      5'd13:   p = 7'h21;
      5'd14:   p = 7'h37;
      5'd15:   p = 7'h46;
      5'd16:   p = 7'h4B;
      5'd17:   p = 7'h32;
      5'd18:   p = 7'h30;
      5'd19:   p = 7'h11;
      5'd20:   p = 7'h34;
      5'd21:   p = 7'h48;
      5'd22:   p = 7'h36;
      5'd23:   p = 7'h49;
      5'd24:   p = 7'h4D;
      5'd25:   p = 7'h43;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

[sv/mcs_ctrl.sv]
module mcs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mcs_pkg::mcs_status_t status_i,
  output mcs_pkg::mcs_cmd_t    cmd_o
);

  mcs_pkg::mcs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    cmd_o.load    = 1'b0;
    cmd_o.emit    = 1'b0;
    cmd_o.advance = 1'b0;
    cmd_o.seg     = mcs_pkg::SEG_ON;
    case (state_q)
      mcs_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_letter) begin
            state_d = status_i.in_has_syms ? mcs_pkg::ST_SYM_ON : mcs_pkg::ST_LETTER_END;
          end else if (status_i.in_space) begin
            state_d = mcs_pkg::ST_WORD_GAP;
          end
        end
      end
      mcs_pkg::ST_SYM_ON: begin
        cmd_o.seg = mcs_pkg::SEG_ON;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mcs_pkg::ST_SYM_OFF;
        end
      end
      mcs_pkg::ST_SYM_OFF: begin
        cmd_o.seg = mcs_pkg::SEG_GAP;
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.advance = 1'b1;
          state_d = status_i.sym_last ? mcs_pkg::ST_LETTER_END : mcs_pkg::ST_SYM_ON;
        end
      end
      mcs_pkg::ST_LETTER_END: begin
        cmd_o.seg = mcs_pkg::SEG_END;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mcs_pkg::ST_IDLE;
        end
      end
      mcs_pkg::ST_WORD_GAP: begin
        cmd_o.seg = mcs_pkg::SEG_WORD;
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = mcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/mcs_dp.sv]
module mcs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [mcs_pkg::CharW-1:0]        char_i,
  input  logic                             cfg_we_i,
  input  logic [mcs_pkg::UnitW-1:0]        cfg_wdata_i,
  input  mcs_pkg::mcs_cmd_t                cmd_i,
  output mcs_pkg::mcs_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             out_lamp_o,
  output logic [mcs_pkg::DurW-1:0]         out_dur_o,
  output logic                             out_last_o
);

  logic [mcs_pkg::UnitW-1:0]   unit_q;
  logic [mcs_pkg::SymW-1:0]    syms_q;
  logic [mcs_pkg::CntW-1:0]    cnt_q;
  logic [mcs_pkg::IdxW-1:0]    idx_q;
  logic                        valid_q;
  logic                        lamp_q;
  logic                        last_q;
  logic [mcs_pkg::DurW-1:0]    dur_q;

  logic [mcs_pkg::CharW-1:0]   chr_fold;
  logic [mcs_pkg::CharW-1:0]   chr_off;
  logic [mcs_pkg::PatW-1:0]    pat;
  logic [mcs_pkg::CntW-1:0]    cnt_raw;
  logic [mcs_pkg::CntW-1:0]    cnt_cap;
  logic                        is_letter;
  logic [mcs_pkg::UnitsW-1:0]  units;
  logic                        out_free;

  always_comb begin
    chr_fold = char_i;
    if (char_i >= mcs_pkg::ChrUpperA && char_i <= mcs_pkg::ChrUpperZ) begin
      chr_fold = char_i + mcs_pkg::CaseFold;
    end
  end

  assign is_letter = (chr_fold >= mcs_pkg::ChrLowerA) && (chr_fold <= mcs_pkg::ChrLowerZ);
  assign chr_off   = chr_fold - mcs_pkg::ChrLowerA;
  assign pat       = mcs_pkg::letter_pattern(chr_off[mcs_pkg::LetterW-1:0]);
  assign cnt_raw   = pat[mcs_pkg::PatW-1:mcs_pkg::SymW];
  assign cnt_cap   = (cnt_raw > mcs_pkg::MaxSymbols) ? mcs_pkg::MaxSymbols : cnt_raw;
  assign out_free  = !valid_q || out_ready_i;

  assign status_o.in_letter   = is_letter;
  assign status_o.in_space    = (chr_fold == mcs_pkg::ChrSpace) ||
                                ((chr_fold >= mcs_pkg::ChrTab) && (chr_fold <= mcs_pkg::ChrCr));
  assign status_o.in_has_syms = (cnt_cap != '0);
  assign status_o.sym_last    = ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign status_o.out_free    = out_free;

  always_comb begin
    case (cmd_i.seg)
      mcs_pkg::SEG_ON:   units = syms_q[idx_q] ? mcs_pkg::UnitsDash : mcs_pkg::UnitsDot;
      mcs_pkg::SEG_GAP:  units = mcs_pkg::UnitsSymGap;
      mcs_pkg::SEG_END:  units = mcs_pkg::UnitsLetEnd;
      mcs_pkg::SEG_WORD: units = mcs_pkg::UnitsWordGap;
      default:           units = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q  <= mcs_pkg::UnitReset;
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unit_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      syms_q <= pat[mcs_pkg::SymW-1:0];
      cnt_q  <= cnt_cap;
      idx_q  <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + 2'd1;
    end
    if (cmd_i.emit) begin
      lamp_q <= (cmd_i.seg == mcs_pkg::SEG_ON);
      last_q <= (cmd_i.seg == mcs_pkg::SEG_END) || (cmd_i.seg == mcs_pkg::SEG_WORD);
      dur_q  <= mcs_pkg::DurW'(units) * {2'b00, unit_q};
    end
  end

  assign out_valid_o = valid_q;
  assign out_lamp_o  = lamp_q;
  assign out_dur_o   = dur_q;
  assign out_last_o  = last_q;

endmodule

[sv/morse_character_sequencer_top.sv]
// Channel   Dir  Fields (tdata/tuser from bit 0 up)             Sideband
// s_axis    in   tdata: character[7:0]                          -
// m_axis    out  tdata: lamp_on[0], duration_ms[18:1], 0[23:19] tlast: last
// cfg       in   cfg_wdata_i: time_unit_ms[15:0]                cfg_we_i
//
// A letter of n symbols gives n lit symbols, each with a gap, then a letter-end gap;
// whitespace a word gap; the controller walks one segment per cycle unless stalled.
// The output register lets the controller return to idle while the final
// segment waits, so the next request is taken then.
// Downstream stalls hold the controller in its current segment.
// Reset: unit length 100 ms, controller idle, output empty.
module morse_character_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // character[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // lamp_on[0], duration_ms[18:1], zero[23:19]
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  mcs_pkg::mcs_cmd_t    cmd;
  mcs_pkg::mcs_status_t status;
  logic                 lamp;
  logic [mcs_pkg::DurW-1:0] dur;

  mcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mcs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_lamp_o  (lamp),
    .out_dur_o   (dur),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b00000, dur, lamp};

endmodule

[sv/mcs_checker.sv]
module mcs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output request changed while stalled");

  a_last_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tdata_o[0])
    else $error("final segment of a character is lit");

  a_space_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i == 8'h20) |=> !s_axis_tready_o)
    else $error("space request did not occupy the sequencer");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[23:19] == 5'b00000))
    else $error("output padding bits set");

endmodule

bind morse_character_sequencer_top mcs_checker u_mcs_checker (.*);
